// ===== rtl/tcw_pkg.sv =====
// tcw_pkg: shared constants, codes, types and helpers for the text console writer
// depends on nothing; used by the interfaces and every rtl module
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_STOP   = 8;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   // field widths
   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int POS_W    = 11;
   localparam int CELL_W   = 16;
   localparam int COL_W    = $clog2(COLUMNS);
   localparam int ROW_W    = $clog2(ROWS);
   localparam int COLX_W   = $clog2(COLUMNS + TAB_STOP);
   localparam int ROWX_W   = $clog2(ROWS + 1);

   // sweep end points
   localparam int LAST_COPY = CELL_COUNT - COLUMNS - 1;
   localparam int LAST_CELL = CELL_COUNT - 1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // character codes
   localparam logic [CHAR_W-1:0] CH_BS         = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LAST_PRINT = 8'h7F;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   // command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // classified operations carried from front to back
   typedef enum logic [2:0] {
      OP_NOP   = 3'd0,
      OP_WRITE = 3'd1,
      OP_BS    = 3'd2,
      OP_TAB   = 3'd3,
      OP_CR    = 3'd4,
      OP_LF    = 3'd5,
      OP_CLEAR = 3'd6,
      OP_READ  = 3'd7
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [CHAR_W-1:0]     char_code;
      logic [POS_W-1:0]      cell_index;
   } entry_type;

   typedef struct packed {
      logic init_busy;
   } status_type;

   function automatic logic [POS_W-1:0] pos_of(input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col);
      return POS_W'(int'(row) * COLUMNS + int'(col));
   endfunction

endpackage

// ===== rtl/tcw_if.sv =====
// tcw_if: valid/ready channel interfaces of the text console writer
// depends on tcw_pkg for field widths
interface tcw_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::CMD_W-1:0]     cmd;
   logic [tcw_pkg::CHAR_W-1:0]    char_code;
   logic [tcw_pkg::POS_W-1:0]     cell_index;

   modport source (output valid, cmd, char_code, cell_index, input ready);
   modport sink   (input valid, cmd, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::POS_W-1:0]     cursor_position;
   logic [tcw_pkg::CELL_W-1:0]    cell_value;

   modport source (output valid, cursor_position, cell_value, input ready);
   modport sink   (input valid, cursor_position, cell_value, output ready);
endinterface

interface tcw_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::ATTR_W-1:0]    attribute;

   modport source (output valid, attribute, input ready);
   modport sink   (input valid, attribute, output ready);
endinterface

// ===== rtl/tcw_front.sv =====
// tcw_front: accepts requests and classifies them into console operations
// depends on tcw_pkg and tcw_req_if
module tcw_front (
   tcw_req_if.sink                req,
   input  tcw_pkg::status_type    status,
   input  logic                   push_ready,
   output logic                   push_valid,
   output tcw_pkg::entry_type     push_entry
);

   tcw_pkg::op_type put_op;
   tcw_pkg::op_type op;

   always_comb begin
      if (req.char_code == tcw_pkg::CH_BS) begin
         put_op = tcw_pkg::OP_BS;
      end else if (req.char_code == tcw_pkg::CH_TAB) begin
         put_op = tcw_pkg::OP_TAB;
      end else if (req.char_code == tcw_pkg::CH_CR) begin
         put_op = tcw_pkg::OP_CR;
      end else if (req.char_code == tcw_pkg::CH_LF) begin
         put_op = tcw_pkg::OP_LF;
      end else if (req.char_code >= tcw_pkg::CH_SPACE &&
                   req.char_code <= tcw_pkg::CH_LAST_PRINT) begin
         put_op = tcw_pkg::OP_WRITE;
      end else begin
         put_op = tcw_pkg::OP_NOP;
      end
   end

   always_comb begin
      unique case (req.cmd)
         tcw_pkg::CMD_PUT:   op = put_op;
         tcw_pkg::CMD_CLEAR: op = tcw_pkg::OP_CLEAR;
         // a read past the end of the store returns zero, same as a no-op
         tcw_pkg::CMD_READ:  op = (req.cell_index < tcw_pkg::POS_W'(tcw_pkg::CELL_COUNT))
                                  ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
         default:            op = tcw_pkg::OP_NOP;
      endcase
   end

   assign req.ready             = push_ready && !status.init_busy;
   assign push_valid            = req.valid && !status.init_busy;
   assign push_entry.op         = op;
   assign push_entry.char_code  = req.char_code;
   assign push_entry.cell_index = req.cell_index;

endmodule

// ===== rtl/tcw_queue.sv =====
// tcw_queue: short fifo of classified operations between front and back
// depends on tcw_pkg
module tcw_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  tcw_pkg::entry_type     push_entry,
   output logic                   push_ready,
   output logic                   pop_valid,
   output tcw_pkg::entry_type     pop_entry,
   input  logic                   pop_ready
);

   tcw_pkg::entry_type               slot_ff [tcw_pkg::QUEUE_DEPTH];
   logic [tcw_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tcw_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tcw_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   function automatic logic [tcw_pkg::QPTR_W-1:0] next_ptr(
         input logic [tcw_pkg::QPTR_W-1:0] ptr);
      return (ptr == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1))
             ? '0 : ptr + tcw_pkg::QPTR_W'(1);
   endfunction

   assign push_ready = (count_ff != tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + tcw_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - tcw_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/tcw_back.sv =====
// tcw_back: cursor, attribute register, cell store and sweep sequencer
// depends on tcw_pkg, tcw_rsp_if and tcw_csr_if
module tcw_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_valid,
   input  tcw_pkg::entry_type     op_entry,
   output logic                   op_ready,
   output tcw_pkg::status_type    status,
   tcw_rsp_if.source              rsp,
   tcw_csr_if.sink                csr
);

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_READ   = 6'b000100,
      ST_SCR_RD = 6'b001000,
      ST_SCR_WR = 6'b010000,
      ST_BLANK  = 6'b100000
   } state_type;

   state_type                        state_ff, state_in;
   logic [tcw_pkg::COL_W-1:0]        col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [tcw_pkg::POS_W-1:0]        ptr_ff, ptr_in;
   logic [tcw_pkg::ATTR_W-1:0]       attr_ff, attr_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [tcw_pkg::CELL_W-1:0]       rsp_cell_ff, rsp_cell_in;
   logic [tcw_pkg::CELL_W-1:0]       rdata_ff;

   logic [tcw_pkg::CELL_W-1:0]       cell_mem [tcw_pkg::CELL_COUNT];

   logic                             we;
   logic [tcw_pkg::POS_W-1:0]        waddr;
   logic [tcw_pkg::CELL_W-1:0]       wdata;
   logic [tcw_pkg::POS_W-1:0]        raddr;
   logic                             slot_free;
   logic                             take;
   logic [tcw_pkg::COLX_W-1:0]       col_x;
   logic [tcw_pkg::ROWX_W-1:0]       row_x;
   logic                             wrap;
   logic                             scroll;
   logic [tcw_pkg::CELL_W-1:0]       blank;
   logic [tcw_pkg::POS_W-1:0]        cur_pos;

   assign blank     = {attr_ff, tcw_pkg::CH_SPACE};
   assign cur_pos   = tcw_pkg::pos_of(row_ff, col_ff);
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign take      = (state_ff == ST_IDLE) && op_valid && slot_free;
   assign op_ready  = take;

   assign status.init_busy = (state_ff == ST_INIT);

   assign csr.ready = 1'b1;
   assign attr_in   = csr.valid ? csr.attribute : attr_ff;

   // cursor motion for put operations, with wrap and scroll detection
   always_comb begin
      col_x = tcw_pkg::COLX_W'(col_ff);
      row_x = tcw_pkg::ROWX_W'(row_ff);
      case (op_entry.op)
         tcw_pkg::OP_WRITE: col_x = tcw_pkg::COLX_W'(col_ff) + tcw_pkg::COLX_W'(1);
         tcw_pkg::OP_BS: begin
            if (col_ff != '0) begin
               col_x = tcw_pkg::COLX_W'(col_ff - tcw_pkg::COL_W'(1));
            end
         end
         tcw_pkg::OP_TAB: col_x = tcw_pkg::COLX_W'(col_ff)
                                  + tcw_pkg::COLX_W'(tcw_pkg::TAB_STOP)
                                  - tcw_pkg::COLX_W'(col_ff
                                       & tcw_pkg::COL_W'(tcw_pkg::TAB_STOP - 1));
         tcw_pkg::OP_CR: col_x = '0;
         tcw_pkg::OP_LF: begin
            col_x = '0;
            row_x = tcw_pkg::ROWX_W'(row_ff) + tcw_pkg::ROWX_W'(1);
         end
         default: ;
      endcase
      wrap = (col_x >= tcw_pkg::COLX_W'(tcw_pkg::COLUMNS));
      if (wrap) begin
         col_x = '0;
         row_x = row_x + tcw_pkg::ROWX_W'(1);
      end
      scroll = (row_x >= tcw_pkg::ROWX_W'(tcw_pkg::ROWS));
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_cell_in  = rsp_cell_ff;
      we           = 1'b0;
      waddr        = ptr_ff;
      wdata        = blank;
      raddr        = '0;
      unique case (state_ff)
         ST_INIT: begin
            // reset contents use the reset attribute even if it is rewritten meanwhile
            we     = 1'b1;
            wdata  = {tcw_pkg::ATTR_RESET, tcw_pkg::CH_SPACE};
            ptr_in = ptr_ff + tcw_pkg::POS_W'(1);
            if (ptr_ff == tcw_pkg::POS_W'(tcw_pkg::LAST_CELL)) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               case (op_entry.op)
                  tcw_pkg::OP_READ: begin
                     raddr    = op_entry.cell_index;
                     state_in = ST_READ;
                  end
                  tcw_pkg::OP_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     ptr_in   = '0;
                     state_in = ST_BLANK;
                  end
                  tcw_pkg::OP_NOP: begin
                     rsp_valid_in = 1'b1;
                     rsp_pos_in   = cur_pos;
                     rsp_cell_in  = '0;
                  end
                  default: begin
                     if (op_entry.op == tcw_pkg::OP_WRITE) begin
                        we    = 1'b1;
                        waddr = cur_pos;
                        wdata = {attr_ff, op_entry.char_code};
                     end
                     col_in = tcw_pkg::COL_W'(col_x);
                     if (scroll) begin
                        row_in   = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                        ptr_in   = '0;
                        state_in = ST_SCR_RD;
                     end else begin
                        row_in       = tcw_pkg::ROW_W'(row_x);
                        rsp_valid_in = 1'b1;
                        rsp_pos_in   = tcw_pkg::pos_of(tcw_pkg::ROW_W'(row_x),
                                                       tcw_pkg::COL_W'(col_x));
                        rsp_cell_in  = '0;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_pos_in   = cur_pos;
            rsp_cell_in  = rdata_ff;
            state_in     = ST_IDLE;
         end
         ST_SCR_RD: begin
            // fetch the cell one row below
            raddr    = ptr_ff + tcw_pkg::POS_W'(tcw_pkg::COLUMNS);
            state_in = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            we     = 1'b1;
            wdata  = rdata_ff;
            ptr_in = ptr_ff + tcw_pkg::POS_W'(1);
            if (ptr_ff == tcw_pkg::POS_W'(tcw_pkg::LAST_COPY)) begin
               state_in = ST_BLANK;
            end else begin
               state_in = ST_SCR_RD;
            end
         end
         ST_BLANK: begin
            we     = 1'b1;
            ptr_in = ptr_ff + tcw_pkg::POS_W'(1);
            if (ptr_ff == tcw_pkg::POS_W'(tcw_pkg::LAST_CELL)) begin
               ptr_in       = '0;
               rsp_valid_in = 1'b1;
               rsp_pos_in   = cur_pos;
               rsp_cell_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         ptr_ff       <= '0;
         attr_ff      <= tcw_pkg::ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         ptr_ff       <= ptr_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff  <= rsp_pos_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   // cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         cell_mem[waddr] <= wdata;
      end
      rdata_ff <= cell_mem[raddr];
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.cursor_position = rsp_pos_ff;
   assign rsp.cell_value      = rsp_cell_ff;

endmodule

// ===== rtl/text_console_writer_top.sv =====
// text_console_writer_top: 80x25 text console with cursor, scroll and cell readback
// throughput: one put per cycle while no scroll and responses are taken; a scroll or a clear
//   holds the back end until its sweep of the cell store ends
// reset: synchronous; a blanking pass follows, requests are held off until it ends,
//   attribute writes are taken at once
module text_console_writer_top (
   input  logic        clock,
   input  logic        reset,
   tcw_req_if.sink     req_ch,
   tcw_rsp_if.source   rsp_ch,
   tcw_csr_if.sink     csr_ch
);

   tcw_pkg::status_type   status;
   logic                  push_valid;
   logic                  push_ready;
   tcw_pkg::entry_type    push_entry;
   logic                  pop_valid;
   logic                  pop_ready;
   tcw_pkg::entry_type    pop_entry;

   tcw_front u_front (
      .req        (req_ch),
      .status     (status),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   tcw_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (pop_valid),
      .op_entry (pop_entry),
      .op_ready (pop_ready),
      .status   (status),
      .rsp      (rsp_ch),
      .csr      (csr_ch)
   );

endmodule
